/* rtl/core/inverse_euler_transform_defines.svh */
// Assertion macros used by the top level.
`ifndef INVERSE_EULER_TRANSFORM_DEFINES_SVH
`define INVERSE_EULER_TRANSFORM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IET_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("iet assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define IET_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("iet assertion failed");

`endif

/* rtl/core/iet_pkg.sv */
// Shared types and constants of the inverse Euler transform block.
package iet_pkg;
	localparam int LEN_W = 7;   // run length, up to 64 terms
	localparam int DATA_W = 64;

	typedef logic [LEN_W-1:0] len_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic busy;
	} back_stat_t;
endpackage

/* rtl/core/iet_if.sv */
// Request and result stream interfaces.
interface iet_in_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] term;
	logic               final_req;
	modport source(output valid, output term, output final_req, input ready);
	modport sink(input valid, input term, input final_req, output ready);
endinterface

interface iet_out_if;
	logic               valid;
	logic               ready;
	logic [5:0]         position;
	logic signed [63:0] coefficient;
	logic               end_of_run;
	modport source(output valid, output position, output coefficient, output end_of_run,
		input ready);
	modport sink(input valid, input position, input coefficient, input end_of_run,
		output ready);
endinterface

/* rtl/core/iet_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module iet_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
	input  logic [WIDTH-1:0]                    wdata,
	input  logic                                re,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
	output logic [WIDTH-1:0]                    rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* rtl/core/iet_job_q.sv */
// Two-entry queue of run lengths between front and back.
module iet_job_q import iet_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  len_t    push_len,
	input  logic    pop,
	output len_t    head_len,
	output q_stat_t stat
);
	len_t       ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign head_len   = ent_q[rptr_q];
	assign stat.empty = (cnt_q == 2'd0);
	assign stat.full  = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

/* rtl/core/iet_front.sv */
// Front: takes term requests, stores them and queues a run at the final one.
module iet_front import iet_pkg::*; #(
	parameter int MAX_LEN = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	iet_in_if.sink                      terms,
	input  q_stat_t                     qstat,
	input  back_stat_t                  bstat,
	output logic                        twe,
	output logic [$clog2(MAX_LEN)-1:0]  twaddr,
	output logic [DATA_W-1:0]           twdata,
	output logic                        push,
	output len_t                        push_len
);
	localparam int IW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);

	logic [CW-1:0] term_count_q;
	logic          accept;
	logic          full;

	// hold off while a run is queued or being worked
	assign terms.ready = qstat.empty && !bstat.busy;
	assign accept      = terms.valid && terms.ready;
	assign full        = (term_count_q == CW'(MAX_LEN));

	assign twe      = accept && !full;
	assign twaddr   = term_count_q[IW-1:0];
	assign twdata   = terms.term;
	assign push     = accept && terms.final_req;
	assign push_len = full ? LEN_W'(term_count_q) : LEN_W'(term_count_q + CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= '0;
		end else if (push) begin
			term_count_q <= '0;
		end else if (twe) begin
			term_count_q <= term_count_q + CW'(1);
		end
	end
endmodule

/* rtl/core/iet_back.sv */
// Back: sequencer that computes the transform of one run and emits results.
module iet_back import iet_pkg::*; #(
	parameter int MAX_LEN = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  q_stat_t                     qstat,
	input  len_t                        head_len,
	output logic                        pop,
	output back_stat_t                  bstat,
	output logic                        tre,
	output logic [$clog2(MAX_LEN)-1:0]  traddr,
	input  logic [DATA_W-1:0]           trdata,
	iet_out_if.source                   results
);
	localparam int IW = $clog2(MAX_LEN);

	typedef enum logic [4:0] {
		B_IDLE, B_EMIT, B_TRD, B_TMUL, B_TACC, B_MOD, B_DMUL, B_DACC,
		B_CRD, B_CM0, B_CM1, B_CM2, B_CM3, B_DIVINIT, B_DIV, B_DIVEND,
		B_CMUL, B_CWR
	} bstate_t;

	bstate_t           state_q;
	len_t              n_q;
	logic [IW-1:0]     i_q, d_q, r_q, j_q, rem_q;
	logic [5:0]        dcnt_q;
	logic              neg_q;
	logic [DATA_W-1:0] t_q, p_q, prod_q, quo_q, a_q;
	logic              ovalid_q;
	logic [5:0]        opos_q;
	logic [DATA_W-1:0] ocoef_q;
	logic              olast_q;

	logic              ofree;
	logic              res_we, res_re, cs_we, cs_re;
	logic [IW-1:0]     res_raddr;
	logic [DATA_W-1:0] res_rdata, cs_rdata, a_new;
	logic [IW:0]       rsh;
	logic              ge;

	assign ofree      = !ovalid_q || results.ready;
	assign bstat.busy = (state_q != B_IDLE);
	assign pop        = (state_q == B_IDLE) && !qstat.empty;

	assign results.valid       = ovalid_q;
	assign results.position    = opos_q;
	assign results.coefficient = ocoef_q;
	assign results.end_of_run  = olast_q;

	assign a_new = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

	// restoring divide step by i
	assign rsh = {rem_q, quo_q[DATA_W-1]};
	assign ge  = (rsh >= {1'b0, i_q});

	assign tre       = (state_q == B_TRD) || (state_q == B_CRD && j_q != i_q);
	assign traddr    = (state_q == B_TRD) ? i_q : (i_q - j_q);
	assign res_re    = (state_q == B_MOD) && (d_q != i_q) && (r_q < d_q) && (r_q == '0);
	assign res_raddr = d_q;
	assign res_we    = (state_q == B_DIVEND);
	assign cs_re     = (state_q == B_CRD) && (j_q != i_q);
	assign cs_we     = (state_q == B_CWR);

	iet_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_res_ram (
		.clk(clk), .we(res_we), .waddr(i_q), .wdata(a_new),
		.re(res_re), .raddr(res_raddr), .rdata(res_rdata)
	);

	iet_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_cs_ram (
		.clk(clk), .we(cs_we), .waddr(i_q), .wdata(p_q + prod_q),
		.re(cs_re), .raddr(j_q), .rdata(cs_rdata)
	);

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_TMUL:  prod_q <= trdata * DATA_W'(i_q);
			B_TACC: begin
				t_q <= prod_q;
				p_q <= '0;
			end
			B_DMUL:  prod_q <= res_rdata * DATA_W'(d_q);
			B_DACC: begin
				t_q <= t_q - prod_q;
				p_q <= p_q + prod_q;
			end
			B_CM0:   prod_q <= DATA_W'(cs_rdata[31:0]) * DATA_W'(trdata[31:0]);
			B_CM1: begin
				t_q    <= t_q - prod_q;
				prod_q <= DATA_W'(cs_rdata[31:0]) * DATA_W'(trdata[63:32]);
			end
			B_CM2: begin
				t_q    <= t_q - {prod_q[31:0], 32'd0};
				prod_q <= DATA_W'(cs_rdata[63:32]) * DATA_W'(trdata[31:0]);
			end
			B_CM3:   t_q <= t_q - {prod_q[31:0], 32'd0};
			B_DIVINIT: begin
				neg_q <= t_q[DATA_W-1];
				quo_q <= t_q[DATA_W-1] ? (DATA_W'(0) - t_q) : t_q;
				rem_q <= '0;
			end
			B_DIV: begin
				rem_q <= ge ? IW'(rsh - {1'b0, i_q}) : IW'(rsh);
				quo_q <= {quo_q[DATA_W-2:0], ge};
			end
			B_DIVEND: a_q <= a_new;
			B_CMUL:  prod_q <= a_q * DATA_W'(i_q);
			default: ;
		endcase
		if (state_q == B_IDLE) begin
			n_q <= head_len;
			a_q <= '0;
		end
		if (state_q == B_EMIT && ofree) begin
			opos_q  <= 6'(i_q);
			ocoef_q <= a_q;
			olast_q <= (LEN_W'(i_q) == n_q - LEN_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			ovalid_q <= 1'b0;
			i_q      <= '0;
			d_q      <= '0;
			r_q      <= '0;
			j_q      <= '0;
			dcnt_q   <= '0;
		end else begin
			// load on emit, else hold until the sink takes it
			ovalid_q <= (state_q == B_EMIT && ofree) || (ovalid_q && !results.ready);
			unique case (state_q)
				B_IDLE: begin
					if (!qstat.empty) begin
						i_q     <= '0;
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (ofree) begin
						if (LEN_W'(i_q) == n_q - LEN_W'(1)) begin
							state_q <= B_IDLE;
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= B_TRD;
						end
					end
				end
				B_TRD:  state_q <= B_TMUL;
				B_TMUL: state_q <= B_TACC;
				B_TACC: begin
					d_q     <= IW'(1);
					r_q     <= i_q;
					state_q <= B_MOD;
				end
				// proper divisors: i mod d by repeated subtraction
				B_MOD: begin
					if (d_q == i_q) begin
						j_q     <= IW'(1);
						state_q <= B_CRD;
					end else if (r_q >= d_q) begin
						r_q <= r_q - d_q;
					end else if (r_q == '0) begin
						state_q <= B_DMUL;
					end else begin
						d_q <= d_q + IW'(1);
						r_q <= i_q;
					end
				end
				B_DMUL: state_q <= B_DACC;
				B_DACC: begin
					d_q     <= d_q + IW'(1);
					r_q     <= i_q;
					state_q <= B_MOD;
				end
				// convolution with stored divisor sums
				B_CRD:  state_q <= (j_q == i_q) ? B_DIVINIT : B_CM0;
				B_CM0:  state_q <= B_CM1;
				B_CM1:  state_q <= B_CM2;
				B_CM2:  state_q <= B_CM3;
				B_CM3: begin
					j_q     <= j_q + IW'(1);
					state_q <= B_CRD;
				end
				B_DIVINIT: begin
					dcnt_q  <= '0;
					state_q <= B_DIV;
				end
				B_DIV: begin
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd63) begin
						state_q <= B_DIVEND;
					end
				end
				B_DIVEND: state_q <= B_CMUL;
				B_CMUL:   state_q <= B_CWR;
				B_CWR:    state_q <= B_EMIT;
				default:  state_q <= B_IDLE;
			endcase
		end
	end
endmodule

/* rtl/core/inverse_euler_transform.sv */
// Top level of the inverse Euler transform block.
// Terms b[0..n-1] arrive one request per cycle while ready is high; the request
// with final_req set closes the run, and terms beyond MAX_LEN are dropped. The
// front stores terms in a RAM and queues the run length; the back then works
// term by term on one sequencer with a 32x32 multiplier and a bit-per-cycle
// divider, and emits a[0..n-1] in order, a[0] = 0. For term i it emits the
// previous result, reads the term, multiplies and loads, then makes a
// subtraction pass over i for each candidate divisor d < i, with a test per
// candidate and a multiply and an accumulate per proper divisor, then takes
// one convolution step per earlier term j from 1 to i-1 (read and partial
// products), and ends with the divide and the divisor-sum update. New term
// requests are held off until the last result has been loaded into the output
// register; that register then waits for the sink while the terms of the next
// run are taken, though the back cannot emit again until the sink takes it.
`include "inverse_euler_transform_defines.svh"

module inverse_euler_transform import iet_pkg::*; #(
	parameter int MAX_LEN = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	iet_in_if.sink    terms,
	iet_out_if.source results
);
	localparam int IW = $clog2(MAX_LEN);

	q_stat_t           qstat;
	back_stat_t        bstat;
	logic              push, pop;
	len_t              push_len, head_len;
	logic              twe, tre;
	logic [IW-1:0]     twaddr, traddr;
	logic [DATA_W-1:0] twdata, trdata;

	// request side: storing and run framing
	iet_front #(.MAX_LEN(MAX_LEN)) u_front (
		.clk(clk), .arst_n(arst_n), .terms(terms), .qstat(qstat), .bstat(bstat),
		.twe(twe), .twaddr(twaddr), .twdata(twdata),
		.push(push), .push_len(push_len)
	);

	// run lengths waiting for the back
	iet_job_q u_job_q (
		.clk(clk), .arst_n(arst_n), .push(push), .push_len(push_len),
		.pop(pop), .head_len(head_len), .stat(qstat)
	);

	// term store: front writes, back reads
	iet_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_term_ram (
		.clk(clk), .we(twe), .waddr(twaddr), .wdata(twdata),
		.re(tre), .raddr(traddr), .rdata(trdata)
	);

	// compute and result side
	iet_back #(.MAX_LEN(MAX_LEN)) u_back (
		.clk(clk), .arst_n(arst_n), .qstat(qstat), .head_len(head_len), .pop(pop),
		.bstat(bstat), .tre(tre), .traddr(traddr), .trdata(trdata),
		.results(results)
	);

	// no term is taken while the back works on a run
	`IET_ASSERT_NOW(a_hold_while_busy, bstat.busy, !terms.ready)
	// a run is never queued onto a full queue
	`IET_ASSERT_NOW(a_push_room, push, !qstat.full)
	// a popped run leaves the back busy next cycle
	`IET_ASSERT_NEXT(a_pop_starts, pop, bstat.busy)
endmodule
